// ----- hdl/dmv_pkg.sv -----
// ----------------------------------------------------------------------------
// Dirty mark vector package
// Shared widths, operation codes, sequencer states and the result word type.
// ----------------------------------------------------------------------------
package dmv_pkg;

  localparam int OP_W         = 3;
  localparam int IDX_W        = 9;
  localparam int LEN_OUT_W    = 9;
  localparam int CAPACITY_DEF = 256;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_QUERY  = 3'd1,
    OP_DIRTY  = 3'd2,
    OP_CLEAN  = 3'd3,
    OP_ERASE  = 3'd4,
    OP_INSERT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_DONE
  } mod_state_e;

  typedef struct packed {
    logic                 dirty;
    logic [LEN_OUT_W-1:0] length_now;
    logic                 refused;
  } res_t;

endpackage

// ----- hdl/dmv_mod.sv -----
// ----------------------------------------------------------------------------
// Dirty mark vector remainder unit
// Restoring remainder of the index by the current length, one bit per cycle.
// ----------------------------------------------------------------------------
module dmv_mod import dmv_pkg::*; #(
  parameter int LEN_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             clear_i,
  input  logic [IDX_W-1:0] dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [LEN_W-1:0] rem_o
);

  localparam int CW = $clog2(IDX_W + 1);

  mod_state_e       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0] dvd_q, dvd_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W:0]   trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MOD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign trial = {rem_q, dvd_q[IDX_W-1]};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    unique case (state_q)
      MOD_IDLE: begin
        if (start_i) begin
          state_d = MOD_RUN;
          cnt_d   = CW'(IDX_W);
          dvd_d   = dividend_i;
          rem_d   = '0;
        end
      end
      MOD_RUN: begin
        // shift in one dividend bit, subtract when it fits
        if (trial >= {1'b0, divisor_i}) begin
          rem_d = LEN_W'(trial - {1'b0, divisor_i});
        end else begin
          rem_d = trial[LEN_W-1:0];
        end
        dvd_d = {dvd_q[IDX_W-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = MOD_DONE;
        end
      end
      MOD_DONE: begin
        if (clear_i) begin
          state_d = MOD_IDLE;
        end
      end
      default: begin
        state_d = MOD_IDLE;
      end
    endcase
  end

  assign done_o = (state_q == MOD_DONE);
  assign rem_o  = rem_q;

endmodule

// ----- hdl/dmv_core.sv -----
// ----------------------------------------------------------------------------
// Dirty mark vector core
// Mark vector and length registers with the single-pass operation logic.
// ----------------------------------------------------------------------------
module dmv_core import dmv_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int LEN_W    = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  op_e              op_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic [IDX_W-1:0] spread_i,
  input  logic [LEN_W-1:0] rem_i,
  output logic [LEN_W-1:0] len_o,
  output logic             needs_mod_o,
  output res_t             res_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int VW = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 2;

  logic [CAPACITY-1:0] marks_q, marks_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [VW-1:0]       v_idx, v_spr, v_len, v_cap, v_rem, v_len_d;
  logic [VW-1:0]       win_w, center, start, win_end;
  logic                full_cover;
  logic [CAPACITY-1:0] win_mask, onehot, below_idx;
  logic                res_dirty, res_refused;

  function automatic logic [CAPACITY-1:0] below(input logic [VW-1:0] n);
    logic [CAPACITY-1:0] r;
    for (int p = 0; p < CAPACITY; p++) begin
      r[p] = (VW'(p) < n);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (fire_i) begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      marks_q <= marks_d;
    end
  end

  assign v_idx = VW'(index_i);
  assign v_spr = VW'(spread_i);
  assign v_len = VW'(len_q);
  assign v_cap = VW'(CAPACITY);
  assign v_rem = VW'(rem_i);

  assign win_w      = (v_spr << 1) + VW'(1);
  assign full_cover = (win_w >= v_len);
  assign center     = (v_idx >= v_len) ? v_rem : v_idx;
  assign start      = (center >= v_spr) ? (center - v_spr) : (center + v_len - v_spr);
  assign win_end    = start + win_w;
  assign win_mask   = (win_end > v_len) ?
                      ((below(v_len) & ~below(start)) | below(win_end - v_len)) :
                      (below(win_end) & ~below(start));
  assign below_idx  = below(v_idx);
  assign onehot     = below(v_idx + VW'(1)) & ~below_idx;

  assign needs_mod_o = (op_i == OP_DIRTY) && (len_q != '0) && !full_cover && (v_idx >= v_len);

  always_comb begin
    marks_d     = marks_q;
    len_d       = len_q;
    res_dirty   = 1'b0;
    res_refused = 1'b0;
    unique case (op_i)
      OP_INIT: begin
        marks_d = '1;
        len_d   = (v_idx > v_cap) ? v_cap[LEN_W-1:0] : v_idx[LEN_W-1:0];
      end
      OP_QUERY: begin
        if (v_idx < v_len) begin
          res_dirty = marks_q[v_idx[AW-1:0]];
        end
      end
      OP_DIRTY: begin
        if (len_q != '0) begin
          marks_d = full_cover ? (marks_q | below(v_len)) : (marks_q | win_mask);
        end
      end
      OP_CLEAN: begin
        if (v_idx < v_len) begin
          marks_d = marks_q & ~onehot;
        end
      end
      OP_ERASE: begin
        if (v_idx < v_len) begin
          marks_d = (marks_q & below_idx) | ((marks_q >> 1) & ~below_idx);
          len_d   = len_q - LEN_W'(1);
        end
      end
      OP_INSERT: begin
        if ((v_len >= v_cap) || (v_idx > v_len)) begin
          res_refused = 1'b1;
        end else begin
          marks_d = (marks_q & below_idx) | ((marks_q << 1) & ~below_idx & ~onehot) | onehot;
          len_d   = len_q + LEN_W'(1);
        end
      end
      default: begin
        marks_d = marks_q;
      end
    endcase
  end

  assign v_len_d = VW'(len_d);
  assign res_o   = {res_dirty, v_len_d[LEN_OUT_W-1:0], res_refused};
  assign len_o   = len_q;

endmodule

// ----- hdl/dirty_mark_vector.sv -----
// ----------------------------------------------------------------------------
// Dirty mark vector
// Ordered vector of dirty marks with init, query, window mark, clean, erase
// and insert operations; one result word per input word.
// ----------------------------------------------------------------------------
// Timing: each word passes the input register and then the result register;
//   one word per cycle sustained while out_stall_i is low and no remainder waits.
// Mark dirty with an index at or beyond the length and a partial window waits
//   while the remainder unit starts and shifts through the 9 index bits.
// Reset clears the length and all valid flags; marks are undefined until init
//   or insert writes them.
module dirty_mark_vector import dmv_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IDX_W-1:0]     index_i,
  input  logic [IDX_W-1:0]     spread_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 dirty_o,
  output logic [LEN_OUT_W-1:0] length_now_o,
  output logic                 refused_o
);

  localparam int LEN_W = $clog2(CAPACITY + 1);

  logic             s_valid_q;
  logic [OP_W-1:0]  s_op_q;
  logic [IDX_W-1:0] s_index_q, s_spread_q;
  logic             out_valid_q;
  res_t             res_q, res;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] rem;
  logic             needs_mod, mod_done, core_ready, s_fire, in_fire;

  assign core_ready = !needs_mod || mod_done;
  assign s_fire     = s_valid_q && core_ready && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !s_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s_valid_q <= 1'b1;
      end else if (s_fire) begin
        s_valid_q <= 1'b0;
      end
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_op_q     <= op_i;
      s_index_q  <= index_i;
      s_spread_q <= spread_i;
    end
    if (s_fire) begin
      res_q <= res;
    end
  end

  dmv_mod #(
    .LEN_W (LEN_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_valid_q && needs_mod),
    .clear_i    (s_fire),
    .dividend_i (s_index_q),
    .divisor_i  (len),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  dmv_core #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s_fire),
    .op_i        (op_e'(s_op_q)),
    .index_i     (s_index_q),
    .spread_i    (s_spread_q),
    .rem_i       (rem),
    .len_o       (len),
    .needs_mod_o (needs_mod),
    .res_o       (res)
  );

  assign out_valid_o  = out_valid_q;
  assign dirty_o      = res_q.dirty;
  assign length_now_o = res_q.length_now;
  assign refused_o    = res_q.refused;

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> out_valid_q)
    else $error("result register not loaded after issue");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_valid_q |-> !in_stall_o)
    else $error("input stalled while input register empty");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s_fire) |=> !out_valid_q)
    else $error("result word repeated after delivery");

  a_wait_on_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && needs_mod && !mod_done) |-> !s_fire)
    else $error("window issued before remainder ready");

endmodule

// ----- tb/sv/tb_dirty_mark_vector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty mark vector testbench
// Drives a directed table and then random operation sequences through the
// valid/stall channels, with random idling on both sides, a long result
// hold-off and a full drain. Each result word is checked field by field
// with its fixed table word, else the bench's cycle-free mark vector model.
// ----------------------------------------------------------------------------
module tb_dirty_mark_vector;
  import dmv_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RANDOM_WORDS = 830;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_AT     = 550;
  localparam int CALM_AT      = 720;
  localparam int HOLD_CYCLES  = 80;
  localparam int STUCK_LIMIT  = 2000;
  localparam int SETTLE       = 20;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    bit   fixed;
    res_t word;
  } typed_word_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] spr;
    typed_word_t      tag;
  } plan_row_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i         = '0;
  logic [IDX_W-1:0]     index_i      = '0;
  logic [IDX_W-1:0]     spread_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic                 dirty_o;
  logic [LEN_OUT_W-1:0] length_now_o;
  logic                 refused_o;

  bit          mark_bits [DEPTH];
  int          mark_len;
  res_t        awaited_words [$];
  typed_word_t typed_words [$];
  plan_row_t   plan_rows [$];
  int          errors;
  int          stuck_cycles;
  bit          hold_req;
  bit          calm;

  dirty_mark_vector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .index_i      (index_i),
    .spread_i     (spread_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dirty_o      (dirty_o),
    .length_now_o (length_now_o),
    .refused_o    (refused_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_t apply_mark_op(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                         logic [IDX_W-1:0] spr);
    res_t r;
    int   i;
    int   pos;
    int   span;
    r = '0;
    case (op)
      OP_INIT: begin
        mark_len = (int'(idx) > DEPTH) ? DEPTH : int'(idx);
        for (i = 0; i < DEPTH; i++) mark_bits[i] = 1'b1;
      end
      OP_QUERY: begin
        if (int'(idx) < mark_len) r.dirty = mark_bits[idx];
      end
      OP_DIRTY: begin
        span = 2 * int'(spr) + 1;
        if (mark_len != 0) begin
          if (span >= mark_len) begin
            for (i = 0; i < mark_len; i++) mark_bits[i] = 1'b1;
          end else begin
            pos = (int'(idx) % mark_len + mark_len - int'(spr) % mark_len) % mark_len;
            for (i = 0; i < span; i++) begin
              mark_bits[pos] = 1'b1;
              pos = (pos + 1 >= mark_len) ? 0 : pos + 1;
            end
          end
        end
      end
      OP_CLEAN: begin
        if (int'(idx) < mark_len) mark_bits[idx] = 1'b0;
      end
      OP_ERASE: begin
        if (int'(idx) < mark_len) begin
          for (i = int'(idx); i + 1 < mark_len; i++) mark_bits[i] = mark_bits[i + 1];
          mark_len--;
        end
      end
      OP_INSERT: begin
        if (mark_len >= DEPTH || int'(idx) > mark_len) begin
          r.refused = 1'b1;
        end else begin
          for (i = mark_len; i > int'(idx); i--) mark_bits[i] = mark_bits[i - 1];
          mark_bits[idx] = 1'b1;
          mark_len++;
        end
      end
      default: ;
    endcase
    r.length_now = mark_len[LEN_OUT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [LEN_OUT_W-1:0] want,
                                      logic [LEN_OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : word_monitor
    typed_word_t tag;
    res_t        want;
    if (in_valid_i && in_stall_o === 1'b0) begin
      want = apply_mark_op(op_i, index_i, spread_i);
      tag  = typed_words.pop_front();
      if (tag.fixed) want = tag.word;
      awaited_words.insert(awaited_words.size(), want);
    end
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: result word with none expected, got dirty %0d length %0d refused %0d",
                 $time, dirty_o, length_now_o, refused_o);
        errors++;
      end else begin
        want = awaited_words.pop_front();
        check_field("dirty", LEN_OUT_W'(want.dirty), LEN_OUT_W'(dirty_o));
        check_field("length_now", want.length_now, length_now_o);
        check_field("refused", LEN_OUT_W'(want.refused), LEN_OUT_W'(refused_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("dirty_mark_vector: mismatch");
      $finish;
    end
  end

  initial begin : result_stall
    int burst;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 7);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] spr,
                           typed_word_t tag);
    int gap;
    typed_words.insert(typed_words.size(), tag);
    in_valid_i <= 1'b1;
    op_i       <= op;
    index_i    <= idx;
    spread_i   <= spr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic add_row(logic [OP_W-1:0] op, int idx, int spr, bit fixed,
                         bit dirty, int len, bit refused);
    plan_row_t row;
    row.op                  = op;
    row.idx                 = IDX_W'(idx);
    row.spr                 = IDX_W'(spr);
    row.tag.fixed           = fixed;
    row.tag.word.dirty      = dirty;
    row.tag.word.length_now = LEN_OUT_W'(len);
    row.tag.word.refused    = refused;
    plan_rows.insert(plan_rows.size(), row);
  endtask

  initial begin : stimulus
    plan_row_t        row;
    typed_word_t      no_tag;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] spr;
    int               roll;
    int               len;

    no_tag = '0;
    // empty vector, reads, a refused insert and an accepted one
    add_row(OP_QUERY,    0,   0,   1, 0, 0,   0);
    add_row(OP_INSERT,   1,   0,   1, 0, 0,   1);
    add_row(OP_DIRTY,    5,   3,   1, 0, 0,   0);
    add_row(OP_ERASE,    0,   0,   1, 0, 0,   0);
    add_row(OP_CLEAN,    0,   0,   1, 0, 0,   0);
    add_row(OP_SPARE_6,  511, 511, 1, 0, 0,   0);
    add_row(OP_INSERT,   0,   0,   1, 0, 1,   0);
    // saturating init and full capacity
    add_row(OP_INIT,     511, 0,   1, 0, 256, 0);
    add_row(OP_QUERY,    255, 0,   1, 1, 256, 0);
    add_row(OP_QUERY,    256, 0,   1, 0, 256, 0);
    add_row(OP_INSERT,   0,   0,   1, 0, 256, 1);
    add_row(OP_CLEAN,    255, 0,   1, 0, 256, 0);
    add_row(OP_QUERY,    255, 0,   1, 0, 256, 0);
    add_row(OP_ERASE,    0,   0,   1, 0, 255, 0);
    add_row(OP_INSERT,   255, 0,   1, 0, 256, 0);
    add_row(OP_SPARE_7,  0,   0,   1, 0, 256, 0);
    // short vector, wrapping and covering windows
    add_row(OP_INIT,     10,  0,   1, 0, 10,  0);
    add_row(OP_CLEAN,    7,   0,   0, 0, 0,   0);
    add_row(OP_CLEAN,    8,   0,   0, 0, 0,   0);
    add_row(OP_DIRTY,    507, 1,   0, 0, 0,   0);
    add_row(OP_QUERY,    8,   0,   0, 0, 0,   0);
    add_row(OP_CLEAN,    9,   0,   0, 0, 0,   0);
    add_row(OP_DIRTY,    0,   1,   0, 0, 0,   0);
    add_row(OP_QUERY,    9,   0,   0, 0, 0,   0);
    add_row(OP_DIRTY,    511, 511, 0, 0, 0,   0);
    add_row(OP_ERASE,    9,   0,   0, 0, 0,   0);
    add_row(OP_INSERT,   300, 0,   1, 0, 9,   1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_rows[k]) begin
      row = plan_rows[k];
      send_word(row.op, row.idx, row.spr, row.tag);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == CALM_AT) calm = 1'b1;
      if (n == DRAIN_AT) begin
        // hold the input until every result is back
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (awaited_words.size() != 0);
      end
      len  = mark_len;
      roll = $urandom_range(0, 99);
      idx  = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(0, 511))
                                         : IDX_W'($urandom_range(0, len));
      spr  = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(0, 511))
                                         : IDX_W'($urandom_range(0, len / 2 + 1));
      if (roll < 4) begin
        op  = OP_INIT;
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 511))
                                          : IDX_W'($urandom_range(0, 40));
      end else if (roll < 34) begin
        op = OP_QUERY;
      end else if (roll < 49) begin
        op = OP_DIRTY;
      end else if (roll < 63) begin
        op = OP_CLEAN;
      end else if (roll < 78) begin
        op = OP_ERASE;
      end else if (roll < 98) begin
        op = OP_INSERT;
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
      end
      send_word(op, idx, spr, no_tag);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_words.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0)
      $display("dirty_mark_vector: match");
    else
      $display("dirty_mark_vector: mismatch");
    $finish;
  end

endmodule
